// File: hw/rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the rational fraction ALU
// Command codes, payload structs and the front-to-back work descriptor.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int FIELD_BITS    = 32;
  localparam int MAG_BITS      = 64;   // magnitude of a cross product sum
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_INC = 3'd4,
    CMD_DEC = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               overflow;
    logic               operands_equal;
  } out_item_t;

  // classified work for the back end, sign and magnitude per part
  typedef struct packed {
    logic                reduce;
    logic                n_neg;
    logic [MAG_BITS-1:0] n_mag;
    logic                d_neg;
    logic [MAG_BITS-1:0] d_mag;
    logic                eq;
  } work_t;

endpackage

// File: hw/rtl/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front: operand intake and cross products
// Registers an item, forms the products over two multiply passes, then
// combines them into a numerator and denominator descriptor.
// ----------------------------------------------------------------------------
module rfa_front import rfa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_take,
  input  in_item_t in_item,
  output logic     busy,
  output logic     wk_valid,
  output work_t    wk,
  input  logic     wk_ready
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  localparam int WB = WORD_BITS;

  fstate_t state_r, state_nxt;
  logic [2:0]   cmd_r;
  logic         an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [WB-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic         eq_r;
  logic [MAG_BITS-1:0] p0_r, p1_r, p2_r;
  logic         s0_r, s1_r, s2_r;

  function automatic logic [WB-1:0] mag_of(input logic [31:0] x);
    logic [WB-1:0] v;
    v = x[WB-1:0];
    return v[WB-1] ? (~v + 1'b1) : v;
  endfunction

  // signed add of sign/magnitude values
  function automatic logic [MAG_BITS:0] sm_add(input logic sa, input logic [MAG_BITS-1:0] ma,
                                               input logic sb, input logic [MAG_BITS-1:0] mb);
    logic [MAG_BITS-1:0] m;
    logic s;
    if (sa == sb) begin
      s = sa; m = ma + mb;
    end else if (ma >= mb) begin
      s = sa; m = ma - mb;
    end else begin
      s = sb; m = mb - ma;
    end
    return {s && (m != '0), m};
  endfunction

  logic [WB-1:0] ma, mb, mc, md;
  logic [MAG_BITS-1:0] prod_a, prod_b;
  logic [MAG_BITS:0] sum;
  work_t wk_nxt;

  always_comb begin
    // pass 1: first product pair, pass 2: second pair
    ma = an_m_r; mb = bd_m_r; mc = ad_m_r; md = bd_m_r;
    unique case (cmd_r)
      CMD_MUL: begin ma = an_m_r; mb = bn_m_r; end
      CMD_DIV: begin ma = an_m_r; mb = bd_m_r; mc = ad_m_r; md = bn_m_r; end
      default: ;
    endcase
    if (state_r == F_MUL2) begin
      ma = bn_m_r; mb = ad_m_r;
    end
    prod_a = MAG_BITS'(ma) * MAG_BITS'(mb);
    prod_b = MAG_BITS'(mc) * MAG_BITS'(md);
  end

  always_comb begin
    wk_nxt = '0;
    wk_nxt.eq = eq_r;
    unique case (cmd_r)
      CMD_ADD, CMD_SUB: begin
        sum = sm_add(s0_r, p0_r, (cmd_r == CMD_SUB) ^ s2_r && (p2_r != '0), p2_r);
        wk_nxt.reduce = 1'b1;
        {wk_nxt.n_neg, wk_nxt.n_mag} = sum;
        wk_nxt.d_neg = s1_r; wk_nxt.d_mag = p1_r;
      end
      CMD_MUL, CMD_DIV: begin
        sum = '0;
        wk_nxt.reduce = 1'b1;
        wk_nxt.n_neg = s0_r; wk_nxt.n_mag = p0_r;
        wk_nxt.d_neg = s1_r; wk_nxt.d_mag = p1_r;
      end
      CMD_INC, CMD_DEC: begin
        sum = sm_add(an_s_r, MAG_BITS'(an_m_r),
                     (cmd_r == CMD_DEC) ^ ad_s_r && (ad_m_r != '0), MAG_BITS'(ad_m_r));
        wk_nxt.reduce = 1'b0;
        {wk_nxt.n_neg, wk_nxt.n_mag} = sum;
        wk_nxt.d_neg = ad_s_r; wk_nxt.d_mag = MAG_BITS'(ad_m_r);
      end
      default: begin
        sum = '0;
        wk_nxt.reduce = 1'b0;
        wk_nxt.n_neg = an_s_r; wk_nxt.n_mag = MAG_BITS'(an_m_r);
        wk_nxt.d_neg = ad_s_r; wk_nxt.d_mag = MAG_BITS'(ad_m_r);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_take) state_nxt = F_MUL1;
      F_MUL1: state_nxt = F_MUL2;
      F_MUL2: state_nxt = F_PUSH;
      F_PUSH: if (wk_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_take) begin
      cmd_r  <= in_item.cmd;
      an_s_r <= in_item.a_num[WB-1]; an_m_r <= mag_of(in_item.a_num);
      ad_s_r <= in_item.a_den[WB-1]; ad_m_r <= mag_of(in_item.a_den);
      bn_s_r <= in_item.b_num[WB-1]; bn_m_r <= mag_of(in_item.b_num);
      bd_s_r <= in_item.b_den[WB-1]; bd_m_r <= mag_of(in_item.b_den);
      eq_r   <= (in_item.a_num[WB-1:0] == in_item.b_num[WB-1:0]) &&
                (in_item.a_den[WB-1:0] == in_item.b_den[WB-1:0]);
    end
    if (state_r == F_MUL1) begin
      p0_r <= prod_a; p1_r <= prod_b;
      s0_r <= (an_s_r ^ ((cmd_r == CMD_MUL) ? bn_s_r : bd_s_r)) && (prod_a != '0);
      s1_r <= (ad_s_r ^ ((cmd_r == CMD_DIV) ? bn_s_r : bd_s_r)) && (prod_b != '0);
    end
    if (state_r == F_MUL2) begin
      p2_r <= prod_a;
      s2_r <= (bn_s_r ^ ad_s_r) && (prod_a != '0);
    end
  end

  assign busy     = (state_r != F_IDLE);
  assign wk_valid = (state_r == F_PUSH);
  assign wk       = wk_nxt;

endmodule

// File: hw/rtl/rfa_queue.sv
// ----------------------------------------------------------------------------
// rfa_queue: small work queue between front and back ends
// Register FIFO, push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module rfa_queue import rfa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  work_t mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r < (AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(QUEUE_DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(QUEUE_DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

// File: hw/rtl/rfa_back.sv
// ----------------------------------------------------------------------------
// rfa_back: gcd reduction and result formatting
// Euclid by a shared restoring divider, one quotient bit per cycle, then two
// exact divisions by the gcd on the same divider.
// ----------------------------------------------------------------------------
module rfa_back import rfa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wk_valid,
  output logic      wk_ready,
  input  work_t     wk,
  output logic      out_strobe,
  output out_item_t out_item
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_GCD  = 7'b0000010,
    B_GDIV = 7'b0000100,
    B_DN   = 7'b0001000,
    B_DNW  = 7'b0010000,
    B_DDW  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bstate_t;

  localparam int CW = $clog2(MAG_BITS);
  localparam int WB = WORD_BITS;

  bstate_t state_r, state_nxt;
  work_t   w_r;
  logic [MAG_BITS-1:0] p_r, q_r, g_r;
  logic [MAG_BITS-1:0] dvd_r, rem_r, dvs_r;
  logic [CW-1:0]       bit_r;
  logic                div_last;
  logic [MAG_BITS-1:0] n_res_r, d_res_r;
  logic                n_neg_r, d_neg_r;
  logic [MAG_BITS:0]   trial;
  logic [MAG_BITS-1:0] rem_sh;

  assign rem_sh   = {rem_r[MAG_BITS-2:0], dvd_r[MAG_BITS-1]};
  assign trial    = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign div_last = (bit_r == CW'(MAG_BITS-1));
  assign wk_ready = (state_r == B_IDLE);

  function automatic logic fits(input logic neg, input logic [MAG_BITS-1:0] m);
    logic [MAG_BITS-1:0] lim;
    lim = MAG_BITS'(1) << (WB-1);
    return neg ? (m <= lim) : (m < lim);
  endfunction

  function automatic logic [31:0] fmt(input logic neg, input logic [MAG_BITS-1:0] m);
    logic [MAG_BITS-1:0] x;
    logic [WB-1:0] lo;
    x  = neg ? (~m + 1'b1) : m;
    lo = x[WB-1:0];
    return 32'(signed'(lo));
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (wk_valid) state_nxt = wk.reduce ? B_GCD : B_OUT;
      B_GCD:  state_nxt = (q_r == '0) ? B_DN : B_GDIV;
      B_GDIV: if (div_last) state_nxt = B_GCD;
      B_DN:   state_nxt = B_DNW;
      B_DNW:  if (div_last) state_nxt = B_DDW;
      B_DDW:  if (div_last) state_nxt = B_OUT;
      B_OUT:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: if (wk_valid) begin
        w_r <= wk;
        p_r <= wk.n_mag; q_r <= wk.d_mag;
        n_res_r <= wk.n_mag; d_res_r <= wk.d_mag;
        n_neg_r <= wk.n_neg; d_neg_r <= wk.d_neg;
      end
      B_GCD: begin
        if (q_r == '0) begin
          // gcd(0,0) is 1; otherwise p holds the gcd magnitude
          g_r <= (p_r == '0) ? MAG_BITS'(1) : p_r;
        end else begin
          dvd_r <= p_r; dvs_r <= q_r; rem_r <= '0; bit_r <= '0;
        end
      end
      B_GDIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= trial[MAG_BITS] ? rem_sh : trial[MAG_BITS-1:0];
        bit_r <= bit_r + 1'b1;
        if (div_last) begin
          p_r <= q_r;
          q_r <= trial[MAG_BITS] ? rem_sh : trial[MAG_BITS-1:0];
        end
      end
      B_DN: begin
        dvd_r <= n_res_r; dvs_r <= g_r; rem_r <= '0; bit_r <= '0;
      end
      B_DNW, B_DDW: begin
        bit_r <= bit_r + 1'b1;
        if (div_last) begin
          rem_r <= '0;
          if (state_r == B_DNW) begin
            n_res_r <= {dvd_r[MAG_BITS-2:0], ~trial[MAG_BITS]};
            dvd_r   <= d_res_r;
          end else begin
            d_res_r <= {dvd_r[MAG_BITS-2:0], ~trial[MAG_BITS]};
          end
        end else begin
          dvd_r <= {dvd_r[MAG_BITS-2:0], ~trial[MAG_BITS]};
          rem_r <= trial[MAG_BITS] ? rem_sh : trial[MAG_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // the Euclid signs alternate between the two part signs; track them here
  logic sp_r, sq_r;
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && wk_valid) begin
      sp_r <= wk.n_neg; sq_r <= wk.d_neg;
    end else if (state_r == B_GDIV && div_last) begin
      sp_r <= sq_r; sq_r <= sp_r;
    end
  end

  logic g_sign;
  assign g_sign = (g_r == MAG_BITS'(1) && p_r == '0) ? 1'b0 : sp_r;

  logic nn, dn;
  assign nn = (n_neg_r ^ g_sign) && (n_res_r != '0);
  assign dn = (d_neg_r ^ g_sign) && (d_res_r != '0);

  logic on_neg, od_neg;
  assign on_neg = w_r.reduce ? nn : n_neg_r;
  assign od_neg = w_r.reduce ? dn : d_neg_r;

  assign out_strobe              = (state_r == B_OUT);
  assign out_item.res_num        = fmt(on_neg, n_res_r);
  assign out_item.res_den        = fmt(od_neg, d_res_r);
  assign out_item.overflow       = !(fits(on_neg, n_res_r) && fits(od_neg, d_res_r));
  assign out_item.operands_equal = w_r.eq;

endmodule

// File: hw/rtl/rational_fraction_alu.sv
// ----------------------------------------------------------------------------
// rational_fraction_alu: signed fraction arithmetic with gcd reduction
//
//   channel  ports                          transfer
//   input    start, busy, in_item           start && !busy
//   result   out_strobe, out_item           out_strobe, one cycle
//
// Front end runs the two multiply passes, then pushes into the queue;
// busy stays high while the queue is full.
// Back end runs Euclid on a bit-serial divider, one division per remainder step,
// then the two exact divisions by the gcd. Reduction-free commands skip the
// divider and go straight to the result. Synchronous active-low reset clears
// all control state. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module rational_fraction_alu import rfa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic  f_valid, f_ready, q_valid, q_ready;
  work_t f_wk, q_wk;

  rfa_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst_n, .in_take(start), .in_item, .busy,
    .wk_valid(f_valid), .wk(f_wk), .wk_ready(f_ready)
  );

  rfa_queue u_queue (
    .clk, .rst_n, .push_valid(f_valid), .push_ready(f_ready), .push_data(f_wk),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_wk)
  );

  rfa_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst_n, .wk_valid(q_valid), .wk_ready(q_ready), .wk(q_wk),
    .out_strobe, .out_item
  );

endmodule

// File: hw/rtl/rfa_checker.sv
// ----------------------------------------------------------------------------
// rfa_checker: port-level checks for the rational fraction ALU
// Watches the command handshake and result strobe.
// ----------------------------------------------------------------------------
module rfa_checker import rfa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy low after transfer");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  a_idle_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe) else $error("not idle after reset");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_item)) else $error("unknown bits in result");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_item
);

// File: sim/rational_fraction_alu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_chk: result checker for the rational fraction ALU
// Watches accepted commands, computes the reduced fraction, overflow and
// equality flags, and compares each strobed result with the oldest one due.
// ----------------------------------------------------------------------------
module rational_fraction_alu_chk import rfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        err_cnt,
  output int        pending
);

  // sign and magnitude value, wide enough for any cross product sum
  typedef struct {
    bit          neg;
    bit [63:0]   mag;
  } frac_part_t;

  out_item_t due_q[$];

  function automatic frac_part_t fp_norm(frac_part_t v);
    if (v.mag == 0) v.neg = 1'b0;
    return v;
  endfunction

  function automatic frac_part_t fp_from(logic [31:0] raw);
    frac_part_t v;
    v.neg = raw[31];
    v.mag = raw[31] ? {32'd0, (~raw) + 32'd1} : {32'd0, raw};
    if (raw == 32'h8000_0000) v.mag = 64'h8000_0000;
    return v;
  endfunction

  function automatic frac_part_t fp_mul(frac_part_t a, frac_part_t b);
    frac_part_t r;
    r.neg = a.neg ^ b.neg;
    r.mag = a.mag * b.mag;
    return fp_norm(r);
  endfunction

  function automatic frac_part_t fp_add(frac_part_t a, frac_part_t b);
    frac_part_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg; r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg; r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg; r.mag = b.mag - a.mag;
    end
    return fp_norm(r);
  endfunction

  function automatic frac_part_t fp_neg(frac_part_t a);
    a.neg = !a.neg;
    return fp_norm(a);
  endfunction

  // Euclid with truncated remainders: remainder keeps the dividend's sign
  function automatic frac_part_t fp_gcd(frac_part_t x, frac_part_t y);
    frac_part_t p, q, r;
    p = x; q = y;
    if (y.mag == 0) begin
      if (x.mag == 0) begin
        r.neg = 1'b0; r.mag = 64'd1;
        return r;
      end
      return x;
    end
    while (q.mag != 0) begin
      r.neg = p.neg;
      r.mag = p.mag % q.mag;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic frac_part_t fp_div(frac_part_t v, frac_part_t t);
    frac_part_t r;
    r.neg = v.neg ^ t.neg;
    r.mag = v.mag / t.mag;
    return fp_norm(r);
  endfunction

  function automatic bit fp_fits(frac_part_t v);
    return v.neg ? (v.mag <= 64'h8000_0000) : (v.mag < 64'h8000_0000);
  endfunction

  function automatic logic [31:0] fp_word(frac_part_t v);
    bit [63:0] x;
    x = v.neg ? (64'd0 - v.mag) : v.mag;
    return x[31:0];
  endfunction

  function automatic out_item_t reduce_fraction(in_item_t it);
    frac_part_t an, ad, bn, bd, zn, zd, g;
    bit         do_red;
    out_item_t  o;
    an = fp_from(it.a_num); ad = fp_from(it.a_den);
    bn = fp_from(it.b_num); bd = fp_from(it.b_den);
    do_red = 1'b1;
    case (it.cmd)
      CMD_ADD: begin
        zn = fp_add(fp_mul(an, bd), fp_mul(bn, ad)); zd = fp_mul(ad, bd);
      end
      CMD_SUB: begin
        zn = fp_add(fp_mul(an, bd), fp_neg(fp_mul(bn, ad))); zd = fp_mul(ad, bd);
      end
      CMD_MUL: begin
        zn = fp_mul(an, bn); zd = fp_mul(ad, bd);
      end
      CMD_DIV: begin
        zn = fp_mul(an, bd); zd = fp_mul(ad, bn);
      end
      CMD_INC: begin
        zn = fp_add(an, ad); zd = ad; do_red = 1'b0;
      end
      CMD_DEC: begin
        zn = fp_add(an, fp_neg(ad)); zd = ad; do_red = 1'b0;
      end
      default: begin
        zn = an; zd = ad; do_red = 1'b0;
      end
    endcase
    if (do_red) begin
      g  = fp_gcd(zn, zd);
      zn = fp_div(zn, g);
      zd = fp_div(zd, g);
    end
    o.res_num        = fp_word(zn);
    o.res_den        = fp_word(zd);
    o.overflow       = !(fp_fits(zn) && fp_fits(zd));
    o.operands_equal = (it.a_num == it.b_num) && (it.a_den == it.b_den);
    return o;
  endfunction

  assign pending = due_q.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      err_cnt <= 0;
    end else begin
      if (out_strobe) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_r = due_q.pop_front();
          if (exp_r.res_num !== out_item.res_num ||
              exp_r.res_den !== out_item.res_den ||
              exp_r.overflow !== out_item.overflow ||
              exp_r.operands_equal !== out_item.operands_equal) begin
            $display({"%0t: mismatch exp num %h den %h ovf %b eq %b, ",
                      "got num %h den %h ovf %b eq %b"},
                     $time, exp_r.res_num, exp_r.res_den, exp_r.overflow,
                     exp_r.operands_equal, out_item.res_num, out_item.res_den,
                     out_item.overflow, out_item.operands_equal);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (start && !busy) due_q.push_back(reduce_fraction(in_item));
    end
  end

endmodule

// File: sim/rational_fraction_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_tb: stimulus and verdict for the rational fraction ALU
// Directed corner operands, then bursty random commands; the checker
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module rational_fraction_alu_tb;
  import rfa_pkg::*;

  localparam int N_RAND = 1450;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  int        err_cnt;
  int        pending;

  rational_fraction_alu DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  rational_fraction_alu_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .err_cnt(err_cnt), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout covering the worst case of about 1500 items
  initial begin
    #1_000_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // drive one command and hold it until the transfer edge
  task automatic send_cmd(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    start         = 1'b1;
    in_item.cmd   = op;
    in_item.a_num = an;
    in_item.a_den = ad;
    in_item.b_num = bn;
    in_item.b_den = bd;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  // mostly small values so Euclid stays short, some full-range and corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 40) - 20;
      4, 5:       return $urandom_range(0, 2000) - 1000;
      6:          return $urandom;
      7:          return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      8: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0;
          default: return 32'h1;
        endcase
      end
      default: return $urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 31) : 32'd0;
    endcase
  endfunction

  initial begin
    logic [31:0] an, ad, bn, bd;
    logic [2:0]  op;
    int          burst;
    start   = 1'b0;
    in_item = '0;
    rst_n   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every command, extreme fields, zero denominators, equal operands
    send_cmd(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_cmd(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_cmd(CMD_MUL, -32'd3, 32'd4, 32'd8, -32'd9);
    send_cmd(CMD_DIV, 32'd2, 32'd3, 32'd4, 32'd5);
    send_cmd(CMD_INC, 32'd5, 32'd7, 32'd0, 32'd1);
    send_cmd(CMD_DEC, 32'd5, 32'd7, 32'd5, 32'd7);
    send_cmd(3'd6, 32'd9, 32'd4, 32'd1, 32'd1);
    send_cmd(3'd7, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
    send_cmd(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(CMD_MUL, 32'd6, 32'd0, 32'd1, 32'd0);
    send_cmd(CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
    send_cmd(CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_cmd(CMD_MUL, 32'h7fff_ffff, 32'd3, 32'h7fff_ffff, 32'd5);
    send_cmd(CMD_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 32'h7fff_fffd);
    send_cmd(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(CMD_INC, 32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
    send_cmd(CMD_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_cmd(CMD_DEC, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cmd(CMD_DIV, -32'd4, -32'd6, 32'd2, -32'd3);
    send_cmd(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // let the queue drain fully once before the random part
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < N_RAND; i += burst) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) begin
        op = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
        an = pick_word(); ad = pick_word(); bn = pick_word(); bd = pick_word();
        // sometimes make the operands identical
        if ($urandom_range(0, 9) == 0) begin
          bn = an; bd = ad;
        end
        send_cmd(op, an, ad, bn, bd);
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
